[rtl/tmma_pkg.sv]
// Shared definitions for the tile matrix multiply-accumulate block.
// Opcodes, word width and the controller-to-datapath command bundle.
// No dependencies.
package tmma_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int IDX_W        = 2;
    localparam int TILE_SIZE_DF = 4;

    localparam logic [OP_W-1:0] OP_LOAD_A    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ACC = 3'd2;
    localparam logic [OP_W-1:0] OP_MAC       = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_ACC  = 3'd4;

    // Controller commands to the datapath, valid for the current cycle.
    typedef struct packed {
        logic load_a;     // write A at request row/col
        logic load_b;     // write B at request row/col
        logic clear_acc;  // drop every accumulator entry to zero
        logic mac_step;   // issue one product at the MAC counters
        logic mac_first;  // first product of an output entry
        logic mac_last;   // last product of an output entry
        logic rd_req;     // read accumulator at request row/col
        logic out_load;   // move read data into the output register
    } t_dp_cmd;

endpackage

[rtl/tmma_datapath.sv]
// Datapath: A, B and accumulator tile memories, the shared MAC pipeline
// and the output register. Depends on tmma_pkg; driven by tmma_ctrl.
module tmma_datapath #(
    parameter int TILE_SIZE = tmma_pkg::TILE_SIZE_DF,
    parameter int K_W       = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tmma_pkg::t_dp_cmd                   i_cmd,
    input  logic [tmma_pkg::IDX_W-1:0]          i_row_index,
    input  logic [tmma_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [tmma_pkg::DATA_W-1:0]  i_value_in,
    input  logic [K_W-1:0]                      i_mac_row,
    input  logic [K_W-1:0]                      i_mac_col,
    input  logic [K_W-1:0]                      i_mac_k,
    output logic signed [tmma_pkg::DATA_W-1:0]  o_value_out
);
    import tmma_pkg::*;

    localparam int CELLS  = TILE_SIZE * TILE_SIZE;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [DATA_W-1:0] r_mem_a [CELLS];
    logic [DATA_W-1:0] r_mem_b [CELLS];
    logic [DATA_W-1:0] r_mem_c [CELLS];
    logic [CELLS-1:0]  r_c_vld;

    logic              w_inside;
    logic [CELL_W-1:0] w_req_addr;
    logic [CELL_W-1:0] w_a_addr;
    logic [CELL_W-1:0] w_b_addr;
    logic [CELL_W-1:0] w_mc_addr;
    logic [CELL_W-1:0] w_c_raddr;
    logic              w_c_ren;

    logic [DATA_W-1:0] r_a_q;
    logic [DATA_W-1:0] r_b_q;
    logic [DATA_W-1:0] r_c_q;
    logic              r_c_vld_q;
    logic              r_rd_inside;

    logic              r_s1_vld, r_s1_first, r_s1_last;
    logic [CELL_W-1:0] r_s1_cell;
    logic              r_s2_vld, r_s2_first, r_s2_last;
    logic [CELL_W-1:0] r_s2_cell;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] w_sum;
    logic [DATA_W-1:0] r_value_out;

    assign w_inside   = (int'(i_row_index) < TILE_SIZE) && (int'(i_col_index) < TILE_SIZE);
    assign w_req_addr = CELL_W'(i_row_index) * CELL_W'(TILE_SIZE) + CELL_W'(i_col_index);
    assign w_a_addr   = CELL_W'(i_mac_row) * CELL_W'(TILE_SIZE) + CELL_W'(i_mac_k);
    assign w_b_addr   = CELL_W'(i_mac_k) * CELL_W'(TILE_SIZE) + CELL_W'(i_mac_col);
    assign w_mc_addr  = CELL_W'(i_mac_row) * CELL_W'(TILE_SIZE) + CELL_W'(i_mac_col);
    assign w_c_raddr  = i_cmd.rd_req ? w_req_addr : w_mc_addr;
    assign w_c_ren    = i_cmd.rd_req || (i_cmd.mac_step && i_cmd.mac_first);

    // Operand memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && w_inside) begin
            r_mem_a[w_req_addr] <= i_value_in;
        end
        if (i_cmd.load_b && w_inside) begin
            r_mem_b[w_req_addr] <= i_value_in;
        end
        if (i_cmd.mac_step) begin
            r_a_q <= r_mem_a[w_a_addr];
            r_b_q <= r_mem_b[w_b_addr];
        end
    end

    // Accumulator memory; writeback from the last MAC stage
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && r_s2_last) begin
            r_mem_c[r_s2_cell] <= w_sum;
        end
        if (w_c_ren) begin
            r_c_q     <= r_mem_c[w_c_raddr];
            r_c_vld_q <= r_c_vld[w_c_raddr];
        end
        if (i_cmd.rd_req) begin
            r_rd_inside <= w_inside;
        end
    end

    // Written-since-clear flags; an unflagged entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
        end else if (i_cmd.clear_acc) begin
            r_c_vld <= '0;
        end else if (r_s2_vld && r_s2_last) begin
            r_c_vld[r_s2_cell] <= 1'b1;
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.mac_step;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_s1_cell  <= w_mc_addr;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_cell  <= r_s1_cell;
        r_prod     <= DATA_W'(r_a_q * r_b_q);
        if (r_s1_vld && r_s1_first) begin
            r_base <= r_c_vld_q ? r_c_q : '0;
        end
        if (r_s2_vld) begin
            r_acc <= w_sum;
        end
        if (i_cmd.out_load) begin
            r_value_out <= (r_rd_inside && r_c_vld_q) ? r_c_q : '0;
        end
    end

    assign w_sum       = (r_s2_first ? r_base : r_acc) + r_prod;
    assign o_value_out = r_value_out;

endmodule

[rtl/tmma_ctrl.sv]
// Controller: request handshake, opcode decode, MAC loop counters and
// output valid. Depends on tmma_pkg; commands tmma_datapath.
module tmma_ctrl #(
    parameter int TILE_SIZE = tmma_pkg::TILE_SIZE_DF,
    parameter int K_W       = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tmma_pkg::OP_W-1:0]   i_opcode,
    output logic                        o_valid,
    input  logic                        i_stall,
    output tmma_pkg::t_dp_cmd           o_cmd,
    output logic [K_W-1:0]              o_mac_row,
    output logic [K_W-1:0]              o_mac_col,
    output logic [K_W-1:0]              o_mac_k
);
    import tmma_pkg::*;

    localparam logic [K_W-1:0] K_LAST = K_W'(TILE_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_RD_WAIT
    } t_state;

    t_state         r_state, n_state;
    logic [K_W-1:0] r_row, n_row;
    logic [K_W-1:0] r_col, n_col;
    logic [K_W-1:0] r_k, n_k;
    logic           r_drain, n_drain;
    logic           r_out_vld, n_out_vld;
    logic           w_accept;
    logic           w_out_free;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        n_drain   = r_drain;
        o_cmd     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode)
                        OP_LOAD_A:    o_cmd.load_a = 1'b1;
                        OP_LOAD_B:    o_cmd.load_b = 1'b1;
                        OP_CLEAR_ACC: o_cmd.clear_acc = 1'b1;
                        OP_MAC: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_k     = '0;
                            n_state = ST_MAC;
                        end
                        OP_READ_ACC: begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                o_cmd.mac_step  = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                o_cmd.mac_last  = (r_k == K_LAST);
                if (r_k != K_LAST) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (r_col != K_LAST) begin
                        n_col = r_col + 1'b1;
                    end else begin
                        n_col = '0;
                        if (r_row != K_LAST) begin
                            n_row = r_row + 1'b1;
                        end else begin
                            n_drain = 1'b0;
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // multiply stage, then accumulate and writeback
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_WAIT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else begin
            n_out_vld = r_out_vld && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
            r_drain   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_k       <= n_k;
            r_drain   <= n_drain;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_mac_row = r_row;
    assign o_mac_col = r_col;
    assign o_mac_k   = r_k;

endmodule

[rtl/tile_matrix_multiply_accumulate.sv]
// Tile matrix multiply-accumulate: loads A/B entries, clears C, C += A*B, reads C.
// Loads and clear take one request per cycle while the controller is idle; a read
// holds off further requests until its result enters the output register, and a
// multiply-accumulate until done. The multiply-accumulate uses one shared 32x32 MAC.
// Reset (i_rst_n, synchronous, active low) idles the controller, drops o_valid
// and marks every C entry zero at once; A and B hold garbage until written.
module tile_matrix_multiply_accumulate #(
    parameter int TILE_SIZE = tmma_pkg::TILE_SIZE_DF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tmma_pkg::OP_W-1:0]           i_opcode,
    input  logic [tmma_pkg::IDX_W-1:0]          i_row_index,
    input  logic [tmma_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [tmma_pkg::DATA_W-1:0]  i_value_in,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tmma_pkg::DATA_W-1:0]  o_value_out
);
    import tmma_pkg::*;

    localparam int K_W = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;

    t_dp_cmd        w_cmd;
    logic [K_W-1:0] w_mac_row;
    logic [K_W-1:0] w_mac_col;
    logic [K_W-1:0] w_mac_k;

    // Controller: takes a request only when idle; a multiply-accumulate walks
    // row, column and inner index with the inner index fastest, then drains
    // the two-stage MAC pipe before the next request. A read may be taken
    // while an earlier result still sits in the output register; it then
    // waits for that slot.
    tmma_ctrl #(
        .TILE_SIZE (TILE_SIZE),
        .K_W       (K_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (w_cmd),
        .o_mac_row (w_mac_row),
        .o_mac_col (w_mac_col),
        .o_mac_k   (w_mac_k)
    );

    // Datapath: tile memories with registered reads, multiply register,
    // accumulate-and-writeback stage, and the result register.
    tmma_datapath #(
        .TILE_SIZE (TILE_SIZE),
        .K_W       (K_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value_in  (i_value_in),
        .i_mac_row   (w_mac_row),
        .i_mac_col   (w_mac_col),
        .i_mac_k     (w_mac_k),
        .o_value_out (o_value_out)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for tile_matrix_multiply_accumulate.
// Sends tile loads, clears, multiply-accumulates and reads, and checks each read result.
// The predictor is a scoreboard class. Depends on tmma_pkg and the block's RTL.

class tile_acc_scoreboard;
    localparam int TILE = tmma_pkg::TILE_SIZE_DF;

    // Predicted tile contents, row-major
    bit [31:0] a_tile   [TILE*TILE];
    bit [31:0] b_tile   [TILE*TILE];
    bit [31:0] acc_tile [TILE*TILE];
    // Accumulator values still owed to accepted read requests, oldest first
    bit [31:0] reads_due [$];
    int        errors;

    function new();
        foreach (a_tile[i]) begin
            a_tile[i]   = '0;
            b_tile[i]   = '0;
            acc_tile[i] = '0;
        end
        errors = 0;
    endfunction

    task report(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    // C += A*B. Sums and products wrap at 32 bits.
    function void accumulate();
        bit [31:0] sum;
        for (int r = 0; r < TILE; r++) begin
            for (int c = 0; c < TILE; c++) begin
                sum = acc_tile[r*TILE + c];
                for (int k = 0; k < TILE; k++) begin
                    sum += a_tile[r*TILE + k] * b_tile[k*TILE + c];
                end
                acc_tile[r*TILE + c] = sum;
            end
        end
    endfunction

    function void note_request(input logic [2:0] op, input logic [1:0] row,
                               input logic [1:0] col, input logic [31:0] val);
        bit in_tile;
        int pos;
        in_tile = (int'(row) < TILE) && (int'(col) < TILE);
        pos     = int'(row) * TILE + int'(col);
        case (op)
            tmma_pkg::OP_LOAD_A:    if (in_tile) a_tile[pos] = val;
            tmma_pkg::OP_LOAD_B:    if (in_tile) b_tile[pos] = val;
            tmma_pkg::OP_CLEAR_ACC: foreach (acc_tile[i]) acc_tile[i] = '0;
            tmma_pkg::OP_MAC:       accumulate();
            tmma_pkg::OP_READ_ACC:  reads_due.push_back(in_tile ? acc_tile[pos] : '0);
            default: ;
        endcase
    endfunction

    task check_result(input logic [31:0] got);
        bit [31:0] want;
        if (reads_due.size() == 0) begin
            report($sformatf("value_out %h with no read outstanding", got));
        end else begin
            want = reads_due.pop_front();
            if (got !== want) begin
                report($sformatf("value_out %h, expected %h", got, want));
            end
        end
    endtask

    function int pending();
        return reads_due.size();
    endfunction
endclass

module tb;
    import tmma_pkg::*;

    localparam int TILE          = TILE_SIZE_DF;
    localparam int ITEMS         = 400;     // random requests, spare opcodes not counted
    localparam int SETTLE_CYCLES = 80;      // beyond a full multiply-accumulate
    localparam int LIMIT_CYCLES  = 300000;

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_opcode;
    logic [IDX_W-1:0]         i_row_index;
    logic [IDX_W-1:0]         i_col_index;
    logic signed [DATA_W-1:0] i_value_in;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_value_out;

    tile_acc_scoreboard sb;
    int                 reqs_sent;
    int                 burst_left;
    int                 cycles = 0;

    tile_matrix_multiply_accumulate #(
        .TILE_SIZE(TILE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: covers a hung handshake or a read that never answers
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side: accepted results are checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_value_out);
        end
    end

    // Result-side back-pressure. Modes change at random intervals: none at all,
    // coin-flip, one stall in three, and long stall runs with short releases.
    initial begin
        int mode;
        int n;
        int run;
        bit hold;
        i_stall = 1'b0;
        n       = 0;
        run     = 0;
        hold    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 150)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall = 1'b0;
                    1: i_stall = 1'($urandom_range(0, 1));
                    2: i_stall = (n % 3 == 0);
                    default: begin
                        if (run == 0) begin
                            hold = !hold;
                            run  = hold ? $urandom_range(1, 15) : $urandom_range(1, 4);
                        end
                        i_stall = hold;
                        run--;
                    end
                endcase
                n++;
            end
        end
    end

    // Mostly small or extreme values, so wrapping shows up often
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 31)) - 32'd16;
            default: return $urandom;
        endcase
    endfunction

    // One request. Entered and left at a falling edge. The sender works in
    // bursts: when one runs out, valid may drop for a random gap. The payload
    // is held until the block takes it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] val);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        i_valid     = 1'b1;
        i_opcode    = op;
        i_row_index = row;
        i_col_index = col;
        i_value_in  = val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(op, row, col, val);
        if (op <= OP_READ_ACC) reqs_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic load_random();
        send_request($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                     IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                     rand_word());
    endtask

    task automatic read_random();
        send_request(OP_READ_ACC, IDX_W'($urandom_range(0, 3)),
                     IDX_W'($urandom_range(0, 3)), $urandom);
    endtask

    // Sender stays idle until every outstanding read has come back
    task automatic wait_for_results();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int  start;
        int  kind;
        bit  drained_once;
        sb           = new();
        reqs_sent    = 0;
        burst_left   = 0;
        drained_once = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_opcode     = OP_LOAD_A;
        i_row_index  = '0;
        i_col_index  = '0;
        i_value_in   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed ---
        // accumulator reads as zero after reset, at the corner indices
        send_request(OP_READ_ACC, 2'd0, 2'd0, 32'hFFFF_FFFF);
        send_request(OP_READ_ACC, 2'd3, 2'd3, 32'h0000_0000);
        // spare opcodes must change nothing and give nothing
        for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) begin
            send_request(OP_W'(k), IDX_W'($urandom_range(0, 3)),
                         IDX_W'($urandom_range(0, 3)), $urandom);
        end
        send_request(OP_CLEAR_ACC, 2'd3, 2'd1, 32'hFFFF_FFFF);
        // extremes in A row 0 and B column 0, so C[0][0] wraps
        send_request(OP_LOAD_A, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD_A, 2'd0, 2'd1, 32'h8000_0000);
        send_request(OP_LOAD_A, 2'd0, 2'd2, 32'hFFFF_FFFF);
        send_request(OP_LOAD_A, 2'd0, 2'd3, 32'h7FFF_FFFF);
        send_request(OP_LOAD_B, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD_B, 2'd1, 2'd0, 32'h8000_0000);
        send_request(OP_LOAD_B, 2'd2, 2'd0, 32'hFFFF_FFFF);
        send_request(OP_LOAD_B, 2'd3, 2'd0, 32'h8000_0000);
        // every A and B entry is written before the first multiply-accumulate;
        // from here on no product can touch an unwritten entry
        for (int r = 1; r < TILE; r++) begin
            for (int c = 0; c < TILE; c++) begin
                send_request(OP_LOAD_A, IDX_W'(r), IDX_W'(c), rand_word());
            end
        end
        for (int r = 0; r < TILE; r++) begin
            for (int c = 1; c < TILE; c++) begin
                send_request(OP_LOAD_B, IDX_W'(r), IDX_W'(c), rand_word());
            end
        end
        send_request(OP_MAC, 2'd2, 2'd2, 32'h8000_0000);
        send_request(OP_READ_ACC, 2'd0, 2'd0, 32'h0);
        send_request(OP_READ_ACC, 2'd0, 2'd3, 32'h0);
        send_request(OP_READ_ACC, 2'd3, 2'd0, 32'h0);
        send_request(OP_READ_ACC, 2'd3, 2'd3, 32'h0);
        // second pass accumulates on top of the first
        send_request(OP_MAC, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_request(OP_READ_ACC, 2'd0, 2'd0, 32'h0);
        send_request(OP_CLEAR_ACC, 2'd0, 2'd0, 32'h0);
        send_request(OP_READ_ACC, 2'd2, 2'd1, 32'h0);

        // --- random ---
        // Mostly well-formed episodes: a few loads, perhaps a clear, one or two
        // multiply-accumulates, then reads. The rest is noise and read bursts.
        start = reqs_sent;
        while (reqs_sent - start < ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                repeat ($urandom_range(1, 12)) load_random();
                if ($urandom_range(0, 2) == 0) begin
                    send_request(OP_CLEAR_ACC, IDX_W'($urandom_range(0, 3)),
                                 IDX_W'($urandom_range(0, 3)), $urandom);
                end
                repeat ($urandom_range(1, 2)) begin
                    send_request(OP_MAC, IDX_W'($urandom_range(0, 3)),
                                 IDX_W'($urandom_range(0, 3)), $urandom);
                end
                repeat ($urandom_range(2, 6)) read_random();
            end else if (kind <= 7) begin
                repeat ($urandom_range(3, 10)) begin
                    send_request(OP_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 3)),
                                 IDX_W'($urandom_range(0, 3)), rand_word());
                end
            end else if (kind == 8) begin
                repeat ($urandom_range(4, 16)) read_random();
            end else begin
                send_request(OP_CLEAR_ACC, IDX_W'($urandom_range(0, 3)),
                             IDX_W'($urandom_range(0, 3)), $urandom);
                repeat ($urandom_range(2, 4)) read_random();
            end
            // once, half way: let the pipe run dry before sending more
            if (!drained_once && reqs_sent - start >= ITEMS / 2) begin
                wait_for_results();
                drained_once = 1'b1;
            end
        end

        // --- wind down ---
        wait_for_results();
        // any stray result after the last read would be caught by the monitor
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/tmma_pkg.sv
rtl/tmma_datapath.sv
rtl/tmma_ctrl.sv
rtl/tile_matrix_multiply_accumulate.sv
verif/tb.sv
